// ===== sv/sitda_pkg.sv =====
// Shared constants and sizing helpers for the signed integer to decimal ASCII unit.
`default_nettype none

package sitda_pkg;

    // Default width of the converted value.
    localparam int VALUE_BITS_DEF = 32;

    // Width of one BCD digit and of a character code.
    localparam int NIB_BITS  = 4;
    localparam int CHAR_BITS = 6;

    // ASCII codes, truncated to the character field.
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

    // Decimal digits needed for the largest magnitude, 2^(bits-1).
    // 1233/4096 approximates log10(2) closely enough up to 64 bits.
    function automatic int num_digits(input int bits);
        return ((bits - 1) * 1233) / 4096 + 1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii_unit.sv =====
// Top level: signed integer to decimal ASCII converter, double-dabble core.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------
//  input     | start, busy          | value (VALUE_BITS, signed)
//  result    | strobe (1 cycle)     | char_code (6), last_char (1)
//
// A transaction is accepted on a clock edge with start high and busy low.
// Conversion runs one shift-and-adjust step of the BCD register per cycle,
// then, for negative values only, a state that emits the minus sign, then
// a walk over the BCD digits from the top; leading zeros are walked but not
// strobed. Busy goes high after the accept edge and stays high until the
// final character is registered; a new transaction can be accepted once busy
// has dropped, not at the edge that takes the final character.
// Each character sits on the result ports for one cycle with strobe high;
// the receiver cannot stall. Reset (rst_n low, asynchronous) returns to idle
// and drops strobe; no clearing pass is needed.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  signed [VALUE_BITS-1:0]         value,
    output logic                                 strobe,
    output logic [sitda_pkg::CHAR_BITS-1:0]      char_code,
    output logic                                 last_char
);

    localparam int NDIG     = sitda_pkg::num_digits(VALUE_BITS);
    localparam int NB       = sitda_pkg::NIB_BITS;
    localparam int BCD_BITS = NDIG * NB;
    localparam int SCNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DCNT_W   = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic [SCNT_W-1:0] SCNT_LAST = SCNT_W'(VALUE_BITS - 1);
    localparam logic [DCNT_W-1:0] DCNT_TOP  = DCNT_W'(NDIG - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [VALUE_BITS-1:0]          mag_reg, mag_next;
    logic [BCD_BITS-1:0]            bcd_reg, bcd_next;
    logic                           neg_reg, neg_next;
    logic                           started_reg, started_next;
    logic [SCNT_W-1:0]              scnt_reg, scnt_next;
    logic [DCNT_W-1:0]              dcnt_reg, dcnt_next;

    logic                           strobe_reg, strobe_next;
    logic [sitda_pkg::CHAR_BITS-1:0] char_reg, char_next;
    logic                           last_reg, last_next;

    logic [BCD_BITS-1:0]            bcd_adj;
    logic [NB-1:0]                  top_nib;
    logic                           show;
    logic [VALUE_BITS-1:0]          in_bits;

    // Add-3 adjust on every digit lane before the shift.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*NB +: NB] >= NB'(5))
                bcd_adj[d*NB +: NB] = bcd_reg[d*NB +: NB] + NB'(3);
            else
                bcd_adj[d*NB +: NB] = bcd_reg[d*NB +: NB];
        end
    end

    assign top_nib = bcd_reg[BCD_BITS-1 -: NB];
    // Digit is shown once the text has started, or is nonzero, or is the units digit.
    assign show    = started_reg || (top_nib != '0) || (dcnt_reg == '0);
    assign in_bits = value;

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        scnt_next    = scnt_reg;
        dcnt_next    = dcnt_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Unsigned magnitude: the most negative value maps to 2^(n-1).
                    neg_next     = in_bits[VALUE_BITS-1];
                    mag_next     = in_bits[VALUE_BITS-1] ? (~in_bits + VALUE_BITS'(1))
                                                         : in_bits;
                    bcd_next     = '0;
                    scnt_next    = '0;
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                mag_next  = {mag_reg[VALUE_BITS-2:0], 1'b0};
                scnt_next = scnt_reg + SCNT_W'(1);
                if (scnt_reg == SCNT_LAST)
                begin
                    dcnt_next  = DCNT_TOP;
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = sitda_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = show;
                char_next   = sitda_pkg::CHAR_ZERO
                              + {{(sitda_pkg::CHAR_BITS-NB){1'b0}}, top_nib};
                last_next   = (dcnt_reg == '0);
                if (show)
                    started_next = 1'b1;
                bcd_next  = {bcd_reg[BCD_BITS-NB-1:0], {NB{1'b0}}};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        scnt_reg    <= scnt_next;
        dcnt_reg    <= dcnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

// ===== sv/sitda_checker.sv =====
// Port-level checker for the signed integer to decimal ASCII unit, with its bind.
`default_nettype none

module sitda_checker #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  start,
    input wire                                  busy,
    input wire signed [VALUE_BITS-1:0]          value,
    input wire                                  strobe,
    input wire [sitda_pkg::CHAR_BITS-1:0]       char_code,
    input wire                                  last_char
);

    logic unused_value;
    assign unused_value = ^value;

    // An accepted transaction keeps the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepted transaction");

    // Only minus sign or decimal digits appear.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == sitda_pkg::CHAR_MINUS
                    || (char_code >= sitda_pkg::CHAR_ZERO && char_code <= 6'd57)))
        else $error("illegal character code");

    // A minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == sitda_pkg::CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last");

    // More characters pending means the unit is still busy.
    a_midtext_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |-> busy)
        else $error("text incomplete while idle");

    // Nothing follows the final character directly.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !strobe)
        else $error("character right after end of text");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
);

`default_nettype wire
